>>> hw/rtl/isl_pkg.sv
`default_nettype none

package isl_pkg;

    localparam int IDX_W     = 7;
    localparam int KEY_IN_W  = 16;
    localparam int PAY_W     = 16;
    localparam int RIDX_W    = 6;
    localparam int LEN_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 64;

    typedef enum logic [1:0] {
        REQ_INSERT,
        REQ_DELETE,
        REQ_READ,
        REQ_SEARCH
    } req_kind_t;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;

    typedef struct packed {
        logic take_new;
        logic take_below;
        logic take_above;
        logic res_clear;
        logic res_shift;
        logic match_key;
        logic match_pos;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/isl_cell.sv
`default_nettype none

module isl_cell
    import isl_pkg::*;
#(
    parameter int KEY_BITS = 16,
    parameter int POS      = 0
) (
    input  wire logic                                  aclk,
    input  wire cell_ctrl_t                            ctrl,
    input  wire logic [KEY_BITS-1:0]                   op_key,
    input  wire logic [KEY_BITS+2*PAY_W-1:0]           new_ent,
    input  wire logic [KEY_BITS+2*PAY_W-1:0]           below_ent,
    input  wire logic [KEY_BITS+2*PAY_W-1:0]           above_ent,
    input  wire logic [KEY_BITS+2*PAY_W+RIDX_W:0]      res_in,
    output logic      [KEY_BITS+2*PAY_W-1:0]           ent_o,
    output logic      [KEY_BITS+2*PAY_W+RIDX_W:0]      res_o
);

    localparam int ENT_W = KEY_BITS + 2 * PAY_W;
    localparam int RES_W = ENT_W + RIDX_W + 1;

    logic [ENT_W-1:0] ent_reg;
    logic [ENT_W-1:0] ent_next;
    logic [RES_W-1:0] res_reg;
    logic [RES_W-1:0] res_next;
    logic             hit;

    assign hit = ctrl.match_pos
               | (ctrl.match_key && (ent_reg[ENT_W-1 -: KEY_BITS] == op_key));

    always_comb begin
        ent_next = ent_reg;
        if (ctrl.take_new) begin
            ent_next = new_ent;
        end else if (ctrl.take_below) begin
            ent_next = below_ent;
        end else if (ctrl.take_above) begin
            ent_next = above_ent;
        end
    end

    // first hit from the low end wins as results travel down the chain
    always_comb begin
        res_next = res_reg;
        if (ctrl.res_clear) begin
            res_next = '0;
        end else if (ctrl.res_shift) begin
            res_next = hit ? {1'b1, RIDX_W'(POS), ent_reg} : res_in;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        res_reg <= res_next;
    end

    assign ent_o = ent_reg;
    assign res_o = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/indexed_shift_list_top.sv
`default_nettype none

// Ordered list of up to DEPTH entries (key plus two 16-bit payload words) held in a
// row of cells, one entry per cell. s_tuser selects insert, delete, read or search.
// Insert and delete shift every affected cell at once in the cycle the item is
// accepted; their result goes through the finish state to the output register. Read
// and search send a result word down the cell row, one cell per cycle, so the lowest
// matching cell wins; that pass covers every cell before the finish state. Rejected
// requests go straight to the finish state. One item is worked on at a time; a new
// item is taken once the previous result sits in the output register.
module indexed_shift_list_top
    import isl_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // index[6:0], key[22:7], payload_a[38:23], payload_b[54:39], zero[55]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[1:0], found[2], result_index[8:3], entry_key[24:9],
    // entry_payload_a[40:25], entry_payload_b[56:41], length[63:57]
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int ENT_W = KEY_BITS + 2 * PAY_W;
    localparam int RES_W = ENT_W + RIDX_W + 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(DEPTH);
    localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       scan_cnt_reg, scan_cnt_next;
    req_kind_t           op_kind_reg, op_kind_next;
    logic [IDX_W-1:0]    op_idx_reg, op_idx_next;
    logic [KEY_BITS-1:0] op_key_reg, op_key_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    req_kind_t           req_kind;
    logic [IDX_W-1:0]    req_idx;
    logic [KEY_BITS-1:0] req_key;
    logic [ENT_W-1:0]    req_ent;
    logic [CMP_W-1:0]    req_idx_ext;
    logic [CMP_W-1:0]    op_idx_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                acc;
    logic                full;
    logic                ins_ok;
    logic                del_ok;
    logic [STATUS_W-1:0] acc_status;
    logic                scanning;
    logic                out_free;
    logic [M_DATA_W-1:0] fin_data;

    logic [ENT_W-1:0]    ent_w [DEPTH];
    logic [RES_W-1:0]    res_w [DEPTH];
    cell_ctrl_t          ctrl_w [DEPTH];

    logic                res0_hit;
    logic [RIDX_W-1:0]   res0_pos;
    logic [ENT_W-1:0]    res0_ent;
    logic                srch_hit;
    logic                rd_ok;

    assign req_kind    = req_kind_t'(s_tuser);
    assign req_idx     = s_tdata[IDX_W-1:0];
    assign req_key     = KEY_BITS'(s_tdata[IDX_W +: KEY_IN_W]);
    assign req_ent     = {req_key, s_tdata[IDX_W+KEY_IN_W +: PAY_W],
                          s_tdata[IDX_W+KEY_IN_W+PAY_W +: PAY_W]};
    assign req_idx_ext = CMP_W'(req_idx);
    assign op_idx_ext  = CMP_W'(op_idx_reg);
    assign cnt_ext     = CMP_W'(count_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(DEPTH));
    assign ins_ok   = acc && (req_kind == REQ_INSERT) && !full && (req_idx_ext <= cnt_ext);
    assign del_ok   = acc && (req_kind == REQ_DELETE) && (req_idx_ext < cnt_ext);
    assign scanning = (state_reg == ST_SCAN);

    always_comb begin
        case (req_kind)
            REQ_INSERT: begin
                if (full) begin
                    acc_status = STS_FULL;
                end else if (req_idx_ext > cnt_ext) begin
                    acc_status = STS_RANGE;
                end else begin
                    acc_status = STS_OK;
                end
            end
            REQ_DELETE, REQ_READ: begin
                acc_status = (req_idx_ext >= cnt_ext) ? STS_RANGE : STS_OK;
            end
            default: begin
                acc_status = STS_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [ENT_W-1:0] below_ent;
            logic [ENT_W-1:0] above_ent;
            logic [RES_W-1:0] res_in;

            always_comb begin
                ctrl_w[gi].take_new   = ins_ok && (req_idx_ext == CMP_W'(gi));
                ctrl_w[gi].take_below = ins_ok && (CMP_W'(gi) > req_idx_ext);
                ctrl_w[gi].take_above = del_ok && (CMP_W'(gi) >= req_idx_ext)
                                        && (gi < DEPTH - 1);
                ctrl_w[gi].res_clear  = acc;
                ctrl_w[gi].res_shift  = scanning;
                ctrl_w[gi].match_key  = scanning && (op_kind_reg == REQ_SEARCH)
                                        && (CMP_W'(gi) < cnt_ext);
                ctrl_w[gi].match_pos  = scanning && (op_kind_reg == REQ_READ)
                                        && (op_idx_ext == CMP_W'(gi));
            end

            if (gi == 0) begin : g_bottom
                assign below_ent = '0;
            end else begin : g_mid_lo
                assign below_ent = ent_w[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_top
                assign above_ent = ent_w[gi];
                assign res_in    = '0;
            end else begin : g_mid_hi
                assign above_ent = ent_w[gi+1];
                assign res_in    = res_w[gi+1];
            end

            isl_cell #(
                .KEY_BITS (KEY_BITS),
                .POS      (gi)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl_w[gi]),
                .op_key    (op_key_reg),
                .new_ent   (req_ent),
                .below_ent (below_ent),
                .above_ent (above_ent),
                .res_in    (res_in),
                .ent_o     (ent_w[gi]),
                .res_o     (res_w[gi])
            );
        end
    endgenerate

    assign res0_hit = res_w[0][RES_W-1];
    assign res0_pos = res_w[0][RES_W-2 -: RIDX_W];
    assign res0_ent = res_w[0][ENT_W-1:0];
    assign srch_hit = (op_kind_reg == REQ_SEARCH) && res0_hit;
    assign rd_ok    = (op_kind_reg == REQ_READ) && (status_reg == STS_OK);

    always_comb begin
        fin_data = '0;
        fin_data[1:0] = status_reg;
        fin_data[2]   = srch_hit;
        fin_data[8:3] = srch_hit ? res0_pos : '0;
        if (rd_ok) begin
            fin_data[24:9]  = KEY_IN_W'(res0_ent[ENT_W-1 -: KEY_BITS]);
            fin_data[40:25] = res0_ent[2*PAY_W-1 -: PAY_W];
            fin_data[56:41] = res0_ent[PAY_W-1:0];
        end
        fin_data[63:57] = LEN_W'(count_reg);
    end

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        op_kind_next  = op_kind_reg;
        op_idx_next   = op_idx_reg;
        op_key_next   = op_key_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    op_kind_next  = req_kind;
                    op_idx_next   = req_idx;
                    op_key_next   = req_key;
                    status_next   = acc_status;
                    scan_cnt_next = '0;
                    if (ins_ok) begin
                        count_next = count_reg + CW'(1);
                    end else if (del_ok) begin
                        count_next = count_reg - CW'(1);
                    end
                    if ((req_kind == REQ_SEARCH)
                        || ((req_kind == REQ_READ) && (acc_status == STS_OK))) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + SW'(1);
                if (scan_cnt_reg == SW'(DEPTH - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = fin_data;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        scan_cnt_reg <= scan_cnt_next;
        op_kind_reg  <= op_kind_next;
        op_idx_reg   <= op_idx_next;
        op_key_reg   <= op_key_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_ok |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_del_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        del_ok |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not shrink the list");

    a_scan_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (scanning && (scan_cnt_reg != SW'(DEPTH - 1))) |=> scanning)
        else $error("scan pass ended early");

    a_hit_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FINISH) && srch_hit) |-> (CMP_W'(res0_pos) < cnt_ext))
        else $error("search hit beyond the list");

endmodule

`default_nettype wire
